// File: rtl/core/mse_pkg.sv
// Shared types and constants of the MIPS subset executor.
// Used by every other file of the block but mse_ram; depends on nothing.

package mse_pkg;

    localparam int XLEN      = 32;
    localparam int NUM_REGS  = 32;
    localparam int REG_AW    = $clog2(NUM_REGS);
    localparam int MEM_WORDS = 1024;
    localparam int MEM_AW    = $clog2(MEM_WORDS);

    localparam logic [REG_AW-1:0] LINK_REG = REG_AW'(31);
    localparam logic [REG_AW-1:0] ZERO_REG = '0;

    typedef enum logic [3:0] {
        KIND_ADD     = 4'd0,
        KIND_SUB     = 4'd1,
        KIND_AND     = 4'd2,
        KIND_ADDI    = 4'd3,
        KIND_LW      = 4'd4,
        KIND_BEQ     = 4'd5,
        KIND_J       = 4'd6,
        KIND_JAL     = 4'd7,
        KIND_JR      = 4'd8,
        KIND_PRELOAD = 4'd9
    } t_kind;

    typedef struct packed {
        logic [3:0]          kind;
        logic [4:0]          dest_reg;
        logic [4:0]          src_a_reg;
        logic [4:0]          src_b_reg;
        logic signed [31:0]  immediate;
        logic signed [31:0]  jump_target;
        logic [9:0]          preload_index;
        logic signed [31:0]  preload_value;
    } t_in_item;

    typedef struct packed {
        logic                reg_written;
        logic [4:0]          written_reg;
        logic signed [31:0]  written_value;
        logic signed [31:0]  new_pc;
        logic                branch_taken;
        logic                error;
    } t_out_item;

    // One register file write.
    typedef struct packed {
        logic              en;
        logic [REG_AW-1:0] addr;
        logic [XLEN-1:0]   data;
    } t_rf_wr;

    // Data memory access requested by the execute logic.
    typedef struct packed {
        logic              re;
        logic [MEM_AW-1:0] raddr;
        logic              we;
        logic [MEM_AW-1:0] waddr;
        logic [XLEN-1:0]   wdata;
    } t_mem_req;

    // Execute result carried into the memory stage.
    typedef struct packed {
        logic              rf_wr;
        logic              lw;
        logic [REG_AW-1:0] rd;
        logic [XLEN-1:0]   val;
        logic [XLEN-1:0]   new_pc;
        logic              taken;
        logic              err;
    } t_ex_res;

endpackage

// File: rtl/core/mse_ifs.sv
// Valid/ready channel interfaces for instruction items and result items.
// Depends on mse_pkg for the payload types.

interface mse_in_if;
    logic              valid;
    logic              ready;
    mse_pkg::t_in_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface mse_out_if;
    logic               valid;
    logic               ready;
    mse_pkg::t_out_item item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// File: rtl/core/mse_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; no package needed.

module mse_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/core/mse_regfile.sv
// Register file: two RAM copies for two read ports, reset-valid bits and bypass.
// Depends on mse_pkg and mse_ram.

module mse_regfile (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_rd_en,
    input  logic [mse_pkg::REG_AW-1:0]    i_ra_addr,
    input  logic [mse_pkg::REG_AW-1:0]    i_rb_addr,
    input  mse_pkg::t_rf_wr               i_wr,
    input  mse_pkg::t_rf_wr               i_byp,
    output logic [mse_pkg::XLEN-1:0]      o_op_a,
    output logic [mse_pkg::XLEN-1:0]      o_op_b
);

    logic [mse_pkg::NUM_REGS-1:0] r_valid;
    logic                         r_va;
    logic                         r_vb;
    logic [mse_pkg::REG_AW-1:0]   r_addr_a;
    logic [mse_pkg::REG_AW-1:0]   r_addr_b;
    mse_pkg::t_rf_wr              r_fw;
    logic [mse_pkg::XLEN-1:0]     ram_a;
    logic [mse_pkg::XLEN-1:0]     ram_b;

    mse_ram #(.WIDTH(mse_pkg::XLEN), .DEPTH(mse_pkg::NUM_REGS)) u_ram_a (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_ra_addr),
        .o_rdata (ram_a)
    );

    mse_ram #(.WIDTH(mse_pkg::XLEN), .DEPTH(mse_pkg::NUM_REGS)) u_ram_b (
        .i_clk   (i_clk),
        .i_we    (i_wr.en),
        .i_waddr (i_wr.addr),
        .i_wdata (i_wr.data),
        .i_re    (i_rd_en),
        .i_raddr (i_rb_addr),
        .o_rdata (ram_b)
    );

    // The write landing on the same edge as the read is not seen by the RAM,
    // so it is kept here until the reading item leaves.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_fw.en <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_fw <= i_wr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_va      <= r_valid[i_ra_addr];
            r_vb      <= r_valid[i_rb_addr];
            r_addr_a  <= i_ra_addr;
            r_addr_b  <= i_rb_addr;
        end
    end

    function automatic logic [mse_pkg::XLEN-1:0] pick(
        input logic [mse_pkg::REG_AW-1:0] addr,
        input logic                       vld,
        input logic [mse_pkg::XLEN-1:0]   ram_q,
        input mse_pkg::t_rf_wr            byp,
        input mse_pkg::t_rf_wr            fw
    );
        logic [mse_pkg::XLEN-1:0] res;
        if (addr == mse_pkg::ZERO_REG) begin
            res = '0;
        end else if (byp.en && byp.addr == addr) begin
            res = byp.data;
        end else if (fw.en && fw.addr == addr) begin
            res = fw.data;
        end else if (vld) begin
            res = ram_q;
        end else begin
            res = '0;
        end
        return res;
    endfunction

    assign o_op_a = pick(r_addr_a, r_va, ram_a, i_byp, r_fw);
    assign o_op_b = pick(r_addr_b, r_vb, ram_b, i_byp, r_fw);

endmodule

// File: rtl/core/mse_exec.sv
// Execute logic: ALU, branch and jump resolution, load address check.
// Depends on mse_pkg.

module mse_exec (
    input  mse_pkg::t_in_item           i_item,
    input  logic [mse_pkg::XLEN-1:0]    i_op_a,
    input  logic [mse_pkg::XLEN-1:0]    i_op_b,
    input  logic [mse_pkg::XLEN-1:0]    i_pc,
    output mse_pkg::t_ex_res            o_res,
    output mse_pkg::t_mem_req           o_mem
);

    logic [mse_pkg::XLEN-1:0] imm;
    logic [mse_pkg::XLEN-1:0] ld_addr;
    logic                     ld_ok;
    logic                     rd_nz;

    assign imm     = mse_pkg::XLEN'(i_item.immediate);
    assign ld_addr = i_op_a + imm;
    assign rd_nz   = (i_item.dest_reg != mse_pkg::ZERO_REG);
    // Non-negative, word aligned and inside the memory.
    assign ld_ok   = !ld_addr[31] && (ld_addr[1:0] == 2'b00)
                     && ({2'b00, ld_addr[31:2]} < 32'(mse_pkg::MEM_WORDS));

    always_comb begin
        o_res        = '0;
        o_res.new_pc = i_pc;
        o_mem        = '0;
        o_mem.raddr  = mse_pkg::MEM_AW'(ld_addr[31:2]);
        o_mem.waddr  = mse_pkg::MEM_AW'(i_item.preload_index);
        o_mem.wdata  = mse_pkg::XLEN'(i_item.preload_value);

        case (i_item.kind)
            mse_pkg::KIND_ADD, mse_pkg::KIND_SUB, mse_pkg::KIND_AND,
            mse_pkg::KIND_ADDI: begin
                if (rd_nz) begin
                    o_res.rf_wr = 1'b1;
                    o_res.rd    = i_item.dest_reg;
                    case (i_item.kind)
                        mse_pkg::KIND_ADD: o_res.val = i_op_a + i_op_b;
                        mse_pkg::KIND_SUB: o_res.val = i_op_a - i_op_b;
                        mse_pkg::KIND_AND: o_res.val = i_op_a & i_op_b;
                        default:           o_res.val = i_op_a + imm;
                    endcase
                end
            end
            mse_pkg::KIND_LW: begin
                o_res.lw  = 1'b1;
                o_res.err = !ld_ok;
                o_mem.re  = ld_ok;
                if (ld_ok && rd_nz) begin
                    o_res.rf_wr = 1'b1;
                    o_res.rd    = i_item.dest_reg;
                end
            end
            mse_pkg::KIND_BEQ: begin
                if (i_op_a == i_op_b) begin
                    o_res.new_pc = i_pc + imm;
                    o_res.taken  = 1'b1;
                end
            end
            mse_pkg::KIND_J: begin
                o_res.new_pc = mse_pkg::XLEN'(i_item.jump_target);
                o_res.taken  = 1'b1;
            end
            mse_pkg::KIND_JAL: begin
                o_res.rf_wr  = 1'b1;
                o_res.rd     = mse_pkg::LINK_REG;
                o_res.val    = i_pc + mse_pkg::XLEN'(1);
                o_res.new_pc = mse_pkg::XLEN'(i_item.jump_target);
                o_res.taken  = 1'b1;
            end
            mse_pkg::KIND_JR: begin
                o_res.new_pc = i_op_a;
                o_res.taken  = 1'b1;
            end
            mse_pkg::KIND_PRELOAD: begin
                o_mem.we = (32'(i_item.preload_index) < 32'(mse_pkg::MEM_WORDS));
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/core/mips_subset_executor.sv
// Top level of the MIPS subset executor: pipeline registers, data memory
// and its clearing sweep. Depends on mse_pkg, mse_ifs, mse_ram,
// mse_regfile and mse_exec.
//
// Usage: decoded instructions arrive as items on the i_in channel and one
// result item per instruction leaves on the o_out channel, in order. Both
// channels use valid/ready; an item moves on a rising edge where both are high.
//
// The pipeline has three registered stages. The execute stage holds the
// accepted item and the register operands read on the accepting edge; the
// memory stage holds the executed result and the load data read from the
// data memory; the output register holds the finished result item. One item
// is accepted per cycle while the execute stage is free to take it and no
// clearing sweep runs; register values written by older items are
// forwarded, so no hazard slows the flow.
//
// Each stage advances when the stage behind it is empty or moving, so the
// block keeps accepting into free stages while a result waits on o_out.
// When the receiver stalls long enough, all three stages fill and i_in.ready
// drops until o_out.ready returns.
//
// Reset clears the PC, the register valid bits and the stage valids. The
// data memory is then zeroed by a sweep of one word per cycle over all 1024
// words, during which i_in.ready stays low.

module mips_subset_executor (
    input  logic           i_clk,
    input  logic           i_rst_n,
    mse_in_if.sink         i_in,
    mse_out_if.source      o_out
);

    // Handshake and stage enables.
    logic en_o;
    logic en_b;
    logic en_a;
    logic accept;
    logic adv_a;

    // Execute stage.
    logic                       r_a_valid;
    mse_pkg::t_in_item          r_a_item;
    logic [mse_pkg::XLEN-1:0]   op_a;
    logic [mse_pkg::XLEN-1:0]   op_b;
    logic [mse_pkg::XLEN-1:0]   r_pc;
    mse_pkg::t_ex_res           ex_res;
    mse_pkg::t_mem_req          mem_req;

    // Memory stage.
    logic                       r_b_valid;
    mse_pkg::t_ex_res           r_b;
    logic [mse_pkg::XLEN-1:0]   mem_q;
    logic [mse_pkg::XLEN-1:0]   b_value;
    mse_pkg::t_rf_wr            b_byp;
    mse_pkg::t_rf_wr            rf_wr;
    mse_pkg::t_out_item         b_out;

    // Output register.
    logic                       r_o_valid;
    mse_pkg::t_out_item         r_o;

    // Data memory clearing sweep.
    logic                        r_clr_busy;
    logic [mse_pkg::MEM_AW-1:0]  r_clr_addr;
    logic                        dm_we;
    logic [mse_pkg::MEM_AW-1:0]  dm_waddr;
    logic [mse_pkg::XLEN-1:0]    dm_wdata;

    assign en_o   = !r_o_valid || o_out.ready;
    assign en_b   = !r_b_valid || en_o;
    assign en_a   = !r_a_valid || en_b;
    assign adv_a  = r_a_valid && en_b;

    assign i_in.ready = en_a && !r_clr_busy;
    assign accept     = i_in.valid && i_in.ready;

    // Register file: read on the accepting edge, written as an item leaves
    // the memory stage. The item in the memory stage is bypassed directly.
    mse_regfile u_regfile (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_ra_addr (i_in.item.src_a_reg),
        .i_rb_addr (i_in.item.src_b_reg),
        .i_wr      (rf_wr),
        .i_byp     (b_byp),
        .o_op_a    (op_a),
        .o_op_b    (op_b)
    );

    mse_exec u_exec (
        .i_item (r_a_item),
        .i_op_a (op_a),
        .i_op_b (op_b),
        .i_pc   (r_pc),
        .o_res  (ex_res),
        .o_mem  (mem_req)
    );

    // Loads and preloads touch the memory only as their item leaves the
    // execute stage, so accesses stay in program order.
    assign dm_we    = r_clr_busy || (adv_a && mem_req.we);
    assign dm_waddr = r_clr_busy ? r_clr_addr : mem_req.waddr;
    assign dm_wdata = r_clr_busy ? '0 : mem_req.wdata;

    mse_ram #(.WIDTH(mse_pkg::XLEN), .DEPTH(mse_pkg::MEM_WORDS)) u_dmem (
        .i_clk   (i_clk),
        .i_we    (dm_we),
        .i_waddr (dm_waddr),
        .i_wdata (dm_wdata),
        .i_re    (adv_a && mem_req.re),
        .i_raddr (mem_req.raddr),
        .o_rdata (mem_q)
    );

    // Memory stage: a load takes its value from the memory read data.
    assign b_value    = (r_b.lw && r_b.rf_wr) ? mem_q : r_b.val;
    assign b_byp.en   = r_b_valid && r_b.rf_wr;
    assign b_byp.addr = r_b.rd;
    assign b_byp.data = b_value;

    assign rf_wr.en   = b_byp.en && en_o;
    assign rf_wr.addr = b_byp.addr;
    assign rf_wr.data = b_byp.data;

    assign b_out.reg_written   = r_b.rf_wr;
    assign b_out.written_reg   = r_b.rd;
    assign b_out.written_value = b_value;
    assign b_out.new_pc        = r_b.new_pc;
    assign b_out.branch_taken  = r_b.taken;
    assign b_out.error         = r_b.err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid  <= 1'b0;
            r_b_valid  <= 1'b0;
            r_o_valid  <= 1'b0;
            r_pc       <= '0;
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else begin
            if (en_a) begin
                r_a_valid <= accept;
            end
            if (en_b) begin
                r_b_valid <= adv_a;
            end
            if (en_o) begin
                r_o_valid <= r_b_valid;
            end
            if (adv_a) begin
                r_pc <= ex_res.new_pc;
            end
            if (r_clr_busy) begin
                r_clr_addr <= r_clr_addr + mse_pkg::MEM_AW'(1);
                if (r_clr_addr == mse_pkg::MEM_AW'(mse_pkg::MEM_WORDS - 1)) begin
                    r_clr_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_item <= i_in.item;
        end
        if (adv_a) begin
            r_b <= ex_res;
        end
        if (en_o && r_b_valid) begin
            r_o <= b_out;
        end
    end

    assign o_out.valid = r_o_valid;
    assign o_out.item  = r_o;

endmodule

// File: bench/mse_result_checker.sv
// Result checker for the MIPS subset executor: watches both channels, predicts each
// result item from its own copy of registers, memory and PC, and compares in order.
// Depends on mse_pkg and the channel interfaces in mse_ifs.

module mse_result_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    mse_in_if           i_instr,
    mse_out_if          i_result,
    output int unsigned o_fail_count,
    output int unsigned o_pending,
    output int unsigned o_checked
);
    import mse_pkg::*;

    logic [XLEN-1:0] gpr [NUM_REGS];
    logic [XLEN-1:0] dmem [MEM_WORDS];
    logic [XLEN-1:0] pc_q;

    t_out_item   expected_results [$];
    int unsigned fails;
    int unsigned checked;

    initial begin
        fails   = 0;
        checked = 0;
    end

    function automatic logic [XLEN-1:0] gpr_read(logic [REG_AW-1:0] idx);
        return (idx == ZERO_REG) ? '0 : gpr[idx];
    endfunction

    // Executes one instruction against the shadow state and returns its result item.
    function automatic t_out_item execute_instr(t_in_item it);
        t_out_item       res;
        logic [XLEN-1:0] a;
        logic [XLEN-1:0] b;
        logic [XLEN-1:0] val;
        logic [XLEN-1:0] addr;
        logic            wr;
        res = '0;
        a   = gpr_read(it.src_a_reg);
        b   = gpr_read(it.src_b_reg);
        val = '0;
        wr  = 1'b0;
        case (it.kind)
            KIND_ADD: begin
                val = a + b;
                wr  = 1'b1;
            end
            KIND_SUB: begin
                val = a - b;
                wr  = 1'b1;
            end
            KIND_AND: begin
                val = a & b;
                wr  = 1'b1;
            end
            KIND_ADDI: begin
                val = a + it.immediate;
                wr  = 1'b1;
            end
            KIND_LW: begin
                addr = a + it.immediate;
                // Negative, misaligned or past the end of memory: rejected.
                if (addr[XLEN-1] || addr[1:0] != 2'b00 || addr[XLEN-1:2] >= MEM_WORDS) begin
                    res.error = 1'b1;
                end else begin
                    val = dmem[addr[MEM_AW+1:2]];
                    wr  = 1'b1;
                end
            end
            KIND_BEQ: begin
                if (a == b) begin
                    pc_q             = pc_q + it.immediate;
                    res.branch_taken = 1'b1;
                end
            end
            KIND_J: begin
                pc_q             = it.jump_target;
                res.branch_taken = 1'b1;
            end
            KIND_JAL: begin
                gpr[LINK_REG]     = pc_q + 1;
                res.reg_written   = 1'b1;
                res.written_reg   = LINK_REG;
                res.written_value = pc_q + 1;
                pc_q              = it.jump_target;
                res.branch_taken  = 1'b1;
            end
            KIND_JR: begin
                pc_q             = a;
                res.branch_taken = 1'b1;
            end
            KIND_PRELOAD: begin
                if (it.preload_index < MEM_WORDS) begin
                    dmem[it.preload_index] = it.preload_value;
                end
            end
            default: ;
        endcase
        // Writes aimed at register zero vanish and report nothing.
        if (wr && it.dest_reg != ZERO_REG) begin
            gpr[it.dest_reg]  = val;
            res.reg_written   = 1'b1;
            res.written_reg   = it.dest_reg;
            res.written_value = val;
        end
        res.new_pc = pc_q;
        return res;
    endfunction

    task automatic check_field(string name, logic [XLEN-1:0] want, logic [XLEN-1:0] got);
        if (want !== got) begin
            $error("result %0d, %s mismatch: expected 0x%08h, actual 0x%08h",
                   checked, name, want, got);
            fails++;
        end
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        t_out_item got;
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) gpr[i] = '0;
            for (int i = 0; i < MEM_WORDS; i++) dmem[i] = '0;
            pc_q = '0;
            expected_results.delete();
        end else begin
            // Results first: an item accepted on this edge cannot come out on it.
            if (i_result.valid && i_result.ready) begin
                got = i_result.item;
                if (expected_results.size() == 0) begin
                    $error("result item arrived with no instruction outstanding");
                    fails++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("reg_written", XLEN'(want.reg_written),
                                XLEN'(got.reg_written));
                    check_field("written_reg", XLEN'(want.written_reg),
                                XLEN'(got.written_reg));
                    check_field("written_value", want.written_value, got.written_value);
                    check_field("new_pc",        want.new_pc,        got.new_pc);
                    check_field("branch_taken", XLEN'(want.branch_taken),
                                XLEN'(got.branch_taken));
                    check_field("error", XLEN'(want.error), XLEN'(got.error));
                    checked++;
                end
            end
            if (i_instr.valid && i_instr.ready) begin
                expected_results.push_back(execute_instr(i_instr.item));
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
        o_checked    <= checked;
    end

endmodule

// File: bench/mips_subset_executor_tb.sv
// Testbench top for the MIPS subset executor: clock, reset, instruction stimulus,
// result-side backpressure and the verdict. Depends on mse_pkg, mse_ifs, the block
// and mse_result_checker.

module mips_subset_executor_tb;
    import mse_pkg::*;

    localparam int RANDOM_ITEMS  = 400;
    localparam int DRAIN_CYCLES  = 8;
    localparam int KIND_CODE_MAX = 15;

    logic clk;
    logic rst_n;

    mse_in_if  instr_ch ();
    mse_out_if result_ch ();

    int unsigned fail_count;
    int unsigned pending;
    int unsigned checked;

    // Pacing: percent of cycles in which the sender holds back, and in which
    // the receiver refuses a result item.
    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    int unsigned n_sent;

    mips_subset_executor u_top (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (instr_ch),
        .o_out   (result_ch)
    );

    mse_result_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_instr      (instr_ch),
        .i_result     (result_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // The receiver decides afresh every cycle whether it takes a result item.
    always @(posedge clk) begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Safety net. This allows far more time than the slowest legal run, including
    // the memory clearing sweep after reset.
    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Start from an item whose every field is random, so the fields an
    // instruction ignores are exercised too; the callers override the rest.
    function automatic t_in_item noisy_instr(t_kind k);
        t_in_item it;
        it.kind          = k;
        it.dest_reg      = 5'($urandom);
        it.src_a_reg     = 5'($urandom);
        it.src_b_reg     = 5'($urandom);
        it.immediate     = $urandom;
        it.jump_target   = $urandom;
        it.preload_index = 10'($urandom);
        it.preload_value = $urandom;
        return it;
    endfunction

    function automatic t_in_item op(t_kind k, logic [4:0] rd, logic [4:0] ra,
                                    logic [4:0] rb, logic [31:0] imm);
        t_in_item it;
        it           = noisy_instr(k);
        it.dest_reg  = rd;
        it.src_a_reg = ra;
        it.src_b_reg = rb;
        it.immediate = imm;
        return it;
    endfunction

    function automatic t_in_item jump(t_kind k, logic [31:0] target);
        t_in_item it;
        it             = noisy_instr(k);
        it.jump_target = target;
        return it;
    endfunction

    function automatic t_in_item preload(logic [9:0] idx, logic [31:0] val);
        t_in_item it;
        it               = noisy_instr(KIND_PRELOAD);
        it.preload_index = idx;
        it.preload_value = val;
        return it;
    endfunction

    // Mostly a small set of registers so that values written earlier get read
    // back, now and then any register at all.
    function automatic logic [4:0] pick_reg();
        return ($urandom_range(99) < 70) ? 5'($urandom_range(7)) : 5'($urandom);
    endfunction

    // Offsets close to zero keep branches and address arithmetic readable.
    function automatic logic [31:0] near_zero();
        return 32'($urandom_range(4095)) - 32'd2048;
    endfunction

    // Offers one item and returns on the edge that accepts it. Valid is only
    // lowered when the sender decides to idle, so back-to-back items keep it high.
    task automatic send_instr(input t_in_item it);
        while ($urandom_range(99) < send_idle_pct) begin
            instr_ch.valid <= 1'b0;
            @(posedge clk);
        end
        instr_ch.valid <= 1'b1;
        instr_ch.item  <= it;
        @(posedge clk);
        while (!instr_ch.ready) @(posedge clk);
        n_sent++;
    endtask

    // Random instructions. Most of the load traffic is built as proper
    // sequences (preload, base register setup, aligned load) so that loads
    // actually return memory data; the rest is broken addresses and noise.
    // Unused kinds do not count toward the total.
    task automatic random_instrs(input int count);
        t_in_item    it;
        int unsigned roll;
        int unsigned idx;
        int unsigned code;
        logic [4:0]  base_reg;
        logic [31:0] off;
        int          done;
        done = 0;
        while (done < count) begin
            roll = $urandom_range(99);
            if (roll < 20) begin
                send_instr(op(t_kind'($urandom_range(KIND_ADD, KIND_AND)),
                              pick_reg(), pick_reg(), pick_reg(), $urandom));
                done++;
            end else if (roll < 32) begin
                send_instr(op(KIND_ADDI, pick_reg(), pick_reg(), pick_reg(),
                              $urandom_range(1) ? $urandom : near_zero()));
                done++;
            end else if (roll < 50) begin
                idx = $urandom_range(MEM_WORDS - 1);
                if ($urandom_range(1) == 1) begin
                    send_instr(preload(idx[9:0], $urandom));
                    done++;
                end
                if ($urandom_range(2) == 0) begin
                    it = op(KIND_LW, pick_reg(), ZERO_REG, pick_reg(), idx * 4);
                end else begin
                    // Split the address between a base register and the offset.
                    base_reg = 5'($urandom_range(1, NUM_REGS - 1));
                    off      = near_zero();
                    send_instr(op(KIND_ADDI, base_reg, ZERO_REG, pick_reg(), idx * 4 - off));
                    done++;
                    it = op(KIND_LW, pick_reg(), base_reg, pick_reg(), off);
                end
                // Now and then knock the address off alignment.
                if ($urandom_range(4) == 0) begin
                    it.immediate = it.immediate + $urandom_range(1, 3);
                end
                send_instr(it);
                done++;
            end else if (roll < 56) begin
                // Wild addresses: nearly all negative or beyond memory.
                send_instr(op(KIND_LW, pick_reg(), pick_reg(), pick_reg(), $urandom));
                done++;
            end else if (roll < 66) begin
                it = op(KIND_BEQ, pick_reg(), pick_reg(), pick_reg(),
                        $urandom_range(1) ? near_zero() : $urandom);
                if ($urandom_range(1) == 1) begin
                    it.src_b_reg = it.src_a_reg;
                end
                send_instr(it);
                done++;
            end else if (roll < 76) begin
                code = $urandom_range(2);
                if (code == 0) begin
                    send_instr(jump(KIND_J, $urandom));
                end else if (code == 1) begin
                    // Call and, usually, return through the link register.
                    send_instr(jump(KIND_JAL, $urandom));
                    if ($urandom_range(3) != 0) begin
                        send_instr(op(KIND_JR, pick_reg(), LINK_REG, pick_reg(), $urandom));
                        done++;
                    end
                end else begin
                    send_instr(op(KIND_JR, pick_reg(), pick_reg(), pick_reg(), $urandom));
                end
                done++;
            end else if (roll < 88) begin
                send_instr(preload(10'($urandom), $urandom));
                done++;
            end else if (roll < 93) begin
                it      = noisy_instr(KIND_ADD);
                it.kind = 4'($urandom_range(int'(KIND_PRELOAD) + 1, KIND_CODE_MAX));
                send_instr(it);
            end else begin
                // Anything at all, unused kinds included.
                it      = noisy_instr(KIND_ADD);
                code    = $urandom_range(KIND_CODE_MAX);
                it.kind = 4'(code);
                send_instr(it);
                if (code <= int'(KIND_PRELOAD)) begin
                    done++;
                end
            end
        end
    endtask

    initial begin
        int unsigned n_directed;
        rst_n           = 1'b0;
        instr_ch.valid  = 1'b0;
        instr_ch.item   = '0;
        n_sent          = 0;
        send_idle_pct   = 13;
        recv_idle_pct   = 72;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. The block spends its first cycles after reset clearing
        // memory; send_instr simply waits for ready through that sweep.
        send_instr(preload(10'd0, 32'h7FFF_FFFF));
        send_instr(preload(10'(MEM_WORDS - 1), 32'h8000_0000));
        send_instr(preload(10'd5, 32'hDEAD_BEEF));
        send_instr(op(KIND_ADDI, 5'd1, ZERO_REG, 5'd0, 32'h7FFF_FFFF));
        send_instr(op(KIND_ADDI, 5'd2, ZERO_REG, 5'd0, 32'd1));
        // Signed overflow wraps.
        send_instr(op(KIND_ADD, 5'd3, 5'd1, 5'd2, 32'd0));
        send_instr(op(KIND_SUB, 5'd4, ZERO_REG, 5'd2, 32'd0));
        send_instr(op(KIND_AND, 5'd5, 5'd4, 5'd1, 32'd0));
        // A write to register zero is dropped, and register zero still reads zero.
        send_instr(op(KIND_ADDI, ZERO_REG, 5'd1, 5'd0, 32'd5));
        send_instr(op(KIND_ADD, 5'd6, ZERO_REG, ZERO_REG, 32'd0));
        // Loads at both ends of memory, then each way a load is rejected.
        send_instr(op(KIND_LW, 5'd7, ZERO_REG, 5'd0, 32'd0));
        send_instr(op(KIND_LW, 5'd8, ZERO_REG, 5'd0, (MEM_WORDS - 1) * 4));
        send_instr(op(KIND_LW, 5'd9, ZERO_REG, 5'd0, MEM_WORDS * 4));
        send_instr(op(KIND_LW, 5'd9, ZERO_REG, 5'd0, 32'd2));
        send_instr(op(KIND_LW, 5'd9, ZERO_REG, 5'd0, 32'h8000_0000));
        send_instr(op(KIND_LW, ZERO_REG, ZERO_REG, 5'd0, 32'd20));
        send_instr(op(KIND_ADDI, 5'd10, ZERO_REG, 5'd0, 32'd40));
        send_instr(op(KIND_LW, 5'd11, 5'd10, 5'd0, 32'hFFFF_FFEC));
        // Branches: taken, not taken, and one that wraps the PC below zero.
        send_instr(op(KIND_BEQ, 5'd0, 5'd2, 5'd2, 32'd100));
        send_instr(op(KIND_BEQ, 5'd0, 5'd1, 5'd2, 32'd7));
        send_instr(op(KIND_BEQ, 5'd0, ZERO_REG, ZERO_REG, 32'hFFFF_FF38));
        // Jumps, with the link value wrapping at both signed and unsigned limits.
        send_instr(jump(KIND_J, 32'h7FFF_FFFF));
        send_instr(jump(KIND_JAL, 32'hFFFF_FFFF));
        send_instr(jump(KIND_JAL, 32'h0000_0000));
        send_instr(op(KIND_JR, 5'd0, LINK_REG, 5'd0, 32'd0));
        send_instr(op(KIND_JR, 5'd0, ZERO_REG, 5'd0, 32'd0));
        n_directed = n_sent;

        // Random part in three pacing modes: slow receiver, slow sender, full rate.
        random_instrs(RANDOM_ITEMS / 3);
        send_idle_pct  = 72;
        recv_idle_pct <= 13;
        random_instrs(RANDOM_ITEMS / 3);
        send_idle_pct  = 0;
        recv_idle_pct <= 0;
        random_instrs(RANDOM_ITEMS - 2 * (RANDOM_ITEMS / 3));
        instr_ch.valid <= 1'b0;

        // The checker's counters are registered, so wait for the next edge before
        // trusting them, then let the pipeline run dry.
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Drove %0d instructions (%0d directed, %0d random) through three pacing modes.",
                 n_sent, n_directed, n_sent - n_directed);
        $display("Compared %0d result items, %0d field mismatches or stray results.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
rtl/core/mse_pkg.sv
rtl/core/mse_ifs.sv
rtl/core/mse_ram.sv
rtl/core/mse_regfile.sv
rtl/core/mse_exec.sv
rtl/core/mips_subset_executor.sv
bench/mse_result_checker.sv
bench/mips_subset_executor_tb.sv
